// ===== hw/rtl/nfpa_pkg.sv =====
package nfpa_pkg;

    // Sizing of the managed region.
    localparam int MAX_BLOCKS = 4096;
    // Page size in bytes; must be a power of two.
    localparam int BLOCK_SIZE = 4096;
    localparam int BLK_SH     = $clog2(BLOCK_SIZE);

    // Page index and page count widths.
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = IDX_W + 1;

    // The used map is stored as words of WORD_W page bits.
    localparam int WORD_W  = 16;
    localparam int WORD_SH = $clog2(WORD_W);
    localparam int NWORDS  = MAX_BLOCKS / WORD_W;
    localparam int WADDR_W = IDX_W - WORD_SH;

    // Field and register widths.
    localparam int ADDR_W    = 32;
    localparam int END_W     = ADDR_W + 2;
    localparam int BCNT_W    = 13;
    localparam int CMP_W     = (BCNT_W > CNT_W) ? BCNT_W : CNT_W;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_MEM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    // Reset value of the page count register.
    localparam logic [BCNT_W-1:0] BCNT_RESET = BCNT_W'(4096);

    // Access request from the controller to the used map.
    typedef struct packed {
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
        logic [WADDR_W-1:0] rd_addr;
    } t_map_req;

endpackage

// ===== hw/rtl/next_fit_page_allocator_top.sv =====
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_ready   i_op, i_address
// result    out        o_out_valid / i_out_ready o_page_address, o_status
// config    in         i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// A free passes from request transfer to result transfer through range check,
// map read, write back and output load; an address out of range skips the map steps.
// An allocate scans the used map one 16-page word at a time after setup; the scan is
// bounded by the single read port of the used-map RAM (at most 257 words).
// The next request is taken in the cycle after the result is loaded.
// Reset clears per-row valid bits at once, so the map needs no clearing pass.
// A result waits in the output register; the next request is taken meanwhile,
// and a stalled output holds the block in its final step.
module next_fit_page_allocator_top import nfpa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_op,
    input  logic [ADDR_W-1:0]    i_address,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ADDR_W-1:0]    o_page_address,
    output logic [STATUS_W-1:0]  o_status,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [ADDR_W-1:0] r_alloc_base;
    logic [BCNT_W-1:0] r_block_count;
    logic [CNT_W-1:0]  eff_count;
    t_map_req          map_req;
    logic [WORD_W-1:0] map_word;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_base  <= '0;
            r_block_count <= BCNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALLOC_BASE:  r_alloc_base  <= i_cfg_data[ADDR_W-1:0];
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[BCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Page count clamped to one page at least and the map size at most.
    always_comb begin
        if (r_block_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (CMP_W'(r_block_count) > CMP_W'(MAX_BLOCKS)) begin
            eff_count = CNT_W'(MAX_BLOCKS);
        end else begin
            eff_count = CNT_W'(r_block_count);
        end
    end

    nfpa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_address      (i_address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_page_address (o_page_address),
        .o_status       (o_status),
        .i_alloc_base   (r_alloc_base),
        .i_eff_count    (eff_count),
        .o_map_req      (map_req),
        .i_map_word     (map_word)
    );

    nfpa_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_word  (map_word)
    );

endmodule

// ===== hw/rtl/nfpa_ram.sv =====
module nfpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== hw/rtl/nfpa_map.sv =====
module nfpa_map import nfpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_map_req          i_req,
    output logic [WORD_W-1:0] o_word
);

    logic [NWORDS-1:0] r_valid;
    logic              r_rd_vld;
    logic [WORD_W-1:0] ram_q;

    // Row valid bits: a row never written since reset reads as all free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // Valid bit of the row being read, aligned with the RAM output.
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[i_req.rd_addr];
    end

    nfpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_en),
        .i_waddr (i_req.wr_addr),
        .i_wdata (i_req.wr_data),
        .i_raddr (i_req.rd_addr),
        .o_rdata (ram_q)
    );

    assign o_word = r_rd_vld ? ram_q : '0;

endmodule

// ===== hw/rtl/nfpa_ctrl.sv =====
module nfpa_ctrl import nfpa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Request channel.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_op,
    input  logic [ADDR_W-1:0]   i_address,
    // Result channel.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [ADDR_W-1:0]   o_page_address,
    output logic [STATUS_W-1:0] o_status,
    // Configuration.
    input  logic [ADDR_W-1:0]   i_alloc_base,
    input  logic [CNT_W-1:0]    i_eff_count,
    // Used map.
    output t_map_req            o_map_req,
    input  logic [WORD_W-1:0]   i_map_word
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_SCAN  = 6'b000100,
        S_FCHK  = 6'b001000,
        S_FRD   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic                  r_op;
    logic [ADDR_W-1:0]     r_addr;
    logic [IDX_W-1:0]      r_cursor, n_cursor;
    logic [IDX_W-1:0]      r_start, n_start;
    logic [CNT_W-1:0]      r_lo, n_lo;
    logic [CNT_W-1:0]      r_hi, n_hi;
    logic                  r_phase2, n_phase2;
    logic [WADDR_W-1:0]    r_word, n_word;
    logic [WORD_SH-1:0]    r_bit, n_bit;
    logic [ADDR_W-1:0]     r_res_page, n_res_page;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic                  r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]     r_out_page;
    logic [STATUS_W-1:0]   r_out_status;

    logic                  in_fire;
    logic                  out_load;

    // Search setup.
    logic [IDX_W-1:0]      c_start;
    logic [CNT_W-1:0]      c_lo1;

    // Word scan.
    logic [CNT_W-1:0]      c_idx;
    logic [WORD_W-1:0]     c_mask;
    logic [WORD_W-1:0]     c_onehot;
    logic [WORD_SH-1:0]    c_fbit;
    logic [IDX_W-1:0]      c_found_idx;
    logic [IDX_W-1:0]      c_hi_m1;
    logic                  c_last;

    // Free checks.
    logic [END_W-1:0]      c_end;
    logic [ADDR_W-1:0]     c_off;
    logic [IDX_W-1:0]      c_fidx;
    logic                  c_out_range;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Starting page of a search: a cursor left past the count starts at the last page.
    always_comb begin
        if (CNT_W'(r_cursor) >= i_eff_count) begin
            c_start = IDX_W'(i_eff_count - CNT_W'(1));
        end else begin
            c_start = r_cursor;
        end
        c_lo1 = CNT_W'(c_start) + CNT_W'(1);
    end

    // Free pages of the current word that lie inside the search window.
    always_comb begin
        c_idx  = '0;
        c_mask = '0;
        c_fbit = '0;
        for (int b = 0; b < WORD_W; b++) begin
            c_idx     = CNT_W'({r_word, WORD_SH'(b)});
            c_mask[b] = !i_map_word[b] && (c_idx >= r_lo) && (c_idx < r_hi);
        end
        c_onehot = c_mask & (~c_mask + WORD_W'(1));
        for (int b = 0; b < WORD_W; b++) begin
            c_fbit = c_fbit | (c_onehot[b] ? WORD_SH'(b) : '0);
        end
        c_found_idx = {r_word, c_fbit};
        c_hi_m1     = IDX_W'(r_hi - CNT_W'(1));
        c_last      = (r_word == c_hi_m1[IDX_W-1:WORD_SH]);
    end

    // Address range check and page index of a free request.
    always_comb begin
        c_end       = END_W'(i_alloc_base) + (END_W'(i_eff_count) << BLK_SH);
        c_out_range = (r_addr < i_alloc_base) || (END_W'(r_addr) >= c_end);
        c_off       = r_addr - i_alloc_base;
        c_fidx      = IDX_W'(c_off >> BLK_SH);
    end

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_cursor     = r_cursor;
        n_start      = r_start;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_phase2     = r_phase2;
        n_word       = r_word;
        n_bit        = r_bit;
        n_res_page   = r_res_page;
        n_res_status = r_res_status;

        o_map_req.wr_en   = 1'b0;
        o_map_req.wr_addr = r_word;
        o_map_req.wr_data = '0;
        o_map_req.rd_addr = r_word;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (i_op == OP_ALLOC) ? S_SETUP : S_FCHK;
                end
            end
            S_SETUP: begin
                n_start      = c_start;
                n_res_page   = '0;
                n_res_status = ST_OK;
                if (c_lo1 != i_eff_count) begin
                    // Search above the start page first.
                    n_lo     = c_lo1;
                    n_hi     = i_eff_count;
                    n_phase2 = 1'b0;
                    n_word   = c_lo1[IDX_W-1:WORD_SH];
                    n_state  = S_SCAN;
                end else if (c_start != '0) begin
                    // Start page is the last one: wrap straight to page zero.
                    n_lo     = '0;
                    n_hi     = CNT_W'(c_start);
                    n_phase2 = 1'b1;
                    n_word   = '0;
                    n_state  = S_SCAN;
                end else begin
                    // Single page: nothing to check.
                    n_cursor     = c_start;
                    n_res_status = ST_OUT_OF_MEM;
                    n_state      = S_DONE;
                end
                o_map_req.rd_addr = n_word;
            end
            S_SCAN: begin
                if (|c_mask) begin
                    o_map_req.wr_en   = 1'b1;
                    o_map_req.wr_data = i_map_word | c_onehot;
                    n_cursor          = c_found_idx;
                    n_res_page        = i_alloc_base + (ADDR_W'(c_found_idx) << BLK_SH);
                    n_state           = S_DONE;
                end else if (!c_last) begin
                    n_word = r_word + WADDR_W'(1);
                end else if (!r_phase2 && (r_start != '0)) begin
                    n_lo     = '0;
                    n_hi     = CNT_W'(r_start);
                    n_phase2 = 1'b1;
                    n_word   = '0;
                end else begin
                    n_cursor     = r_start;
                    n_res_status = ST_OUT_OF_MEM;
                    n_state      = S_DONE;
                end
                o_map_req.rd_addr = n_word;
            end
            S_FCHK: begin
                n_res_page = '0;
                n_word     = c_fidx[IDX_W-1:WORD_SH];
                n_bit      = c_fidx[WORD_SH-1:0];
                if (c_out_range) begin
                    n_res_status = ST_RANGE;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_FRD;
                end
                o_map_req.rd_addr = n_word;
            end
            S_FRD: begin
                if (i_map_word[r_bit]) begin
                    o_map_req.wr_en   = 1'b1;
                    o_map_req.wr_data = i_map_word & ~(WORD_W'(1) << r_bit);
                    n_res_status      = ST_OK;
                end else begin
                    n_res_status = ST_ALREADY_FREE;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: holds one result while the next request is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= i_op;
            r_addr <= i_address;
        end
        r_start      <= n_start;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_phase2     <= n_phase2;
        r_word       <= n_word;
        r_bit        <= n_bit;
        r_res_page   <= n_res_page;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out_page   <= r_res_page;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_page_address = r_out_page;
    assign o_status       = r_out_status;

    // The search window is never empty while scanning.
    a_scan_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_lo < r_hi))
        else $error("scan window is empty");

    // The map is written only when a word has just been read.
    a_map_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_map_req.wr_en |-> ((r_state == S_SCAN) || (r_state == S_FRD)))
        else $error("map write outside a read-modify-write state");

    // A free request never returns a page address.
    a_free_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_op == OP_FREE)) |-> (r_res_page == '0))
        else $error("free request returns a page address");

    // A finished result always reaches the output register.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("result not loaded into the output register");

endmodule

// ===== test/next_fit_page_allocator_top_test.sv =====
module next_fit_page_allocator_top_test;
    import nfpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 150;
    localparam int PHASES      = 9;

    // Scoreboard: tracks the page map and cursor, and holds the results still owed.
    class page_alloc_scoreboard;
        bit                  used_map [MAX_BLOCKS];
        int unsigned         cursor;
        logic [ADDR_W-1:0]   alloc_base;
        logic [BCNT_W-1:0]   block_count;
        logic [ADDR_W-1:0]   owed_page [$];
        logic [STATUS_W-1:0] owed_status [$];
        int                  errors;

        function void reset_state();
            foreach (used_map[i]) used_map[i] = 1'b0;
            cursor      = 0;
            alloc_base  = '0;
            block_count = BCNT_RESET;
            errors      = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
            if (idx == CFG_ALLOC_BASE) begin
                alloc_base = data;
            end else begin
                block_count = data[BCNT_W-1:0];
            end
        endfunction

        // A count of zero acts as one page, and anything above the map size is clamped.
        function int unsigned effective_count();
            int unsigned n;
            n = block_count;
            if (n == 0) n = 1;
            if (n > MAX_BLOCKS) n = MAX_BLOCKS;
            return n;
        endfunction

        function int unsigned pending();
            return owed_page.size();
        endfunction

        // Works out the result of one accepted request and updates the map.
        function void note_request(input logic req_op, input logic [ADDR_W-1:0] req_addr,
                                   output logic [ADDR_W-1:0] page,
                                   output logic [STATUS_W-1:0] status);
            int unsigned n;
            int unsigned start;
            int unsigned idx;
            bit          found;
            logic [63:0] limit;
            n      = effective_count();
            page   = '0;
            status = ST_OK;
            if (req_op == OP_ALLOC) begin
                // A lowered count pulls the cursor back to the last page.
                if (cursor >= n) cursor = n - 1;
                start  = cursor;
                cursor = (cursor + 1 >= n) ? 0 : cursor + 1;
                found  = 1'b0;
                while (!found && cursor != start) begin
                    if (!used_map[cursor]) begin
                        used_map[cursor] = 1'b1;
                        page  = alloc_base + 32'(cursor) * 32'(BLOCK_SIZE);
                        found = 1'b1;
                    end else begin
                        cursor = (cursor + 1 >= n) ? 0 : cursor + 1;
                    end
                end
                if (!found) status = ST_OUT_OF_MEM;
            end else begin
                limit = 64'(alloc_base) + 64'(n) * 64'(BLOCK_SIZE);
                if (req_addr < alloc_base || 64'(req_addr) >= limit) begin
                    status = ST_RANGE;
                end else begin
                    idx = (req_addr - alloc_base) / BLOCK_SIZE;
                    if (idx >= n) begin
                        status = ST_RANGE;
                    end else if (!used_map[idx]) begin
                        status = ST_ALREADY_FREE;
                    end else begin
                        used_map[idx] = 1'b0;
                    end
                end
            end
            owed_page.push_back(page);
            owed_status.push_back(status);
        endfunction

        // Compares one result transfer with the oldest result still owed.
        function void check_result(input logic [ADDR_W-1:0] page,
                                   input logic [STATUS_W-1:0] status);
            logic [ADDR_W-1:0]   exp_page;
            logic [STATUS_W-1:0] exp_status;
            if (owed_page.size() == 0) begin
                $display("%0t: result with no request pending: page %h status %0d",
                         $realtime, page, status);
                errors++;
            end else begin
                exp_page   = owed_page.pop_front();
                exp_status = owed_status.pop_front();
                if (page !== exp_page) begin
                    $display("%0t: page_address expected %h, actual %h",
                             $realtime, exp_page, page);
                    errors++;
                end
                if (status !== exp_status) begin
                    $display("%0t: status expected %0d, actual %0d",
                             $realtime, exp_status, status);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 op       = OP_ALLOC;
    logic [ADDR_W-1:0]    address  = '0;
    logic                 o_out_valid;
    logic                 out_ready = 1'b0;
    logic [ADDR_W-1:0]    o_page_address;
    logic [STATUS_W-1:0]  o_status;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = CFG_ALLOC_BASE;
    logic [CFG_W-1:0]     cfg_data = '0;

    page_alloc_scoreboard sb;
    logic [ADDR_W-1:0]    live_pages [$];
    bit                   no_gaps = 1'b0;
    int                   hold_cycles = 0;
    int                   idle_cycles = 0;

    next_fit_page_allocator_top u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (op),
        .i_address      (address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_page_address (o_page_address),
        .o_status       (o_status),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // The receiver stalls at random, independent of the valid signal.
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            out_ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold_cycles <= pick_gap();
        end
    end

    // Every result transfer is checked against the scoreboard.
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) sb.check_result(o_page_address, o_status);
    end

    // The watchdog ends a run in which no transfer happens for too long.
    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
            $display("next_fit_page_allocator_top: mismatch");
            $finish;
        end
    end

    // Sends one request and notes it once the transfer has happened.
    task automatic send_request(input logic req_op, input logic [ADDR_W-1:0] req_addr);
        int                  gap;
        logic [ADDR_W-1:0]   page;
        logic [STATUS_W-1:0] status;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= req_op;
        address  <= req_addr;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        sb.note_request(req_op, req_addr, page, status);
        if (req_op == OP_ALLOC && status == ST_OK) live_pages.push_back(page);
    endtask

    task automatic wait_results();
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Stops the request stream and lets the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        wait_results();
        repeat (8) @(posedge clk);
    endtask

    // Registers change only while the block is idle.
    task automatic set_registers(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] count);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ALLOC_BASE;
        cfg_data <= base;
        @(posedge clk);
        sb.write_reg(CFG_ALLOC_BASE, base);
        cfg_idx  <= CFG_BLOCK_COUNT;
        cfg_data <= count;
        @(posedge clk);
        sb.write_reg(CFG_BLOCK_COUNT, count);
        cfg_we <= 1'b0;
        live_pages.delete();
    endtask

    // One random request: mostly allocations and frees of real pages, some noise.
    task automatic send_random_request();
        int unsigned       n;
        int                r;
        int                j;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] top;
        n   = sb.effective_count();
        r   = $urandom_range(0, 99);
        top = sb.alloc_base + 32'(n) * 32'(BLOCK_SIZE);
        if (r < 50) begin
            send_request(OP_ALLOC, $urandom());
        end else if (r < 72 && live_pages.size() > 0) begin
            j = $urandom_range(0, live_pages.size() - 1);
            a = live_pages[j];
            live_pages.delete(j);
            if ($urandom_range(0, 3) == 0) a = a + $urandom_range(1, BLOCK_SIZE - 1);
            send_request(OP_FREE, a);
        end else if (r < 90) begin
            a = sb.alloc_base + 32'($urandom_range(0, n - 1)) * 32'(BLOCK_SIZE);
            if ($urandom_range(0, 2) == 0) a = a + $urandom_range(0, BLOCK_SIZE - 1);
            send_request(OP_FREE, a);
        end else begin
            case ($urandom_range(0, 3))
                0: a = $urandom();
                1: a = sb.alloc_base - $urandom_range(1, BLOCK_SIZE);
                2: a = top + $urandom_range(0, 3);
                default: a = top - 1;
            endcase
            send_request(OP_FREE, a);
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_base();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return $urandom() & ~32'(BLOCK_SIZE - 1);
            2: return $urandom();
            3: return 32'hFFFF_FFFF;
            default: return {8'($urandom_range(0, 255)), 24'h0};
        endcase
    endfunction

    // Counts lean small so the map fills up; the register's spare bits get noise.
    function automatic logic [CFG_W-1:0] pick_count();
        logic [CFG_W-1:0] c;
        case ($urandom_range(0, 9))
            6: c = MAX_BLOCKS;
            7: c = 0;
            8: c = $urandom_range(MAX_BLOCKS + 1, 8191);
            9: c = $urandom_range(25, MAX_BLOCKS);
            default: c = $urandom_range(1, 24);
        endcase
        if ($urandom_range(0, 3) == 0) c = c | ($urandom() & ~32'h1FFF);
        return c;
    endfunction

    initial begin
        sb = new;
        sb.reset_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: first pages, page zero never handed out first,
        // double free, unaligned free and both ends of the range.
        send_request(OP_ALLOC, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'h0000_0000);
        send_request(OP_FREE, 32'h0000_0000);
        send_request(OP_FREE, 32'h0000_1000);
        send_request(OP_FREE, 32'h0000_1000);
        send_request(OP_FREE, 32'h0000_2ABC);
        send_request(OP_FREE, 32'h0100_0000);
        send_request(OP_FREE, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'h00FF_FFFF);
        send_request(OP_ALLOC, 32'h5555_5555);

        // Two pages at the top of the address space: the cursor sits past the
        // lowered count, and the second page address wraps to zero.
        set_registers(32'hFFFF_F000, 32'd2);
        send_request(OP_ALLOC, 32'hAAAA_AAAA);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_FREE, 32'h0000_0000);
        send_request(OP_FREE, 32'hFFFF_F800);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_ALLOC, 32'h0);

        // A single page can never be allocated.
        set_registers(32'h1234_5000, 32'd1);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_FREE, 32'h1234_5000);
        send_request(OP_FREE, 32'h1234_6000);
        send_request(OP_FREE, 32'h1234_4FFF);

        // A zero count behaves as one page.
        set_registers(32'h0, 32'd0);
        send_request(OP_ALLOC, 32'h0);

        // The largest count register value is clamped to the map size.
        set_registers(32'h0, 32'd8191);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_FREE, 32'h00FF_F000);
        send_request(OP_FREE, 32'h0100_0000);

        // Random phases, the first three at fixed extremes of the registers.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_registers(32'h0, MAX_BLOCKS);
                1: set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: set_registers(32'h0, 32'd1);
                default: set_registers(pick_base(), pick_count());
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Halfway through, the sender holds off until all results are back.
                if (k == PHASE_ITEMS / 2) begin
                    in_valid <= 1'b0;
                    wait_results();
                end
                send_random_request();
            end
        end
        no_gaps = 1'b0;

        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("next_fit_page_allocator_top: match");
        end else begin
            $display("next_fit_page_allocator_top: mismatch");
        end
        $finish;
    end

endmodule
